// ===== src/ntfrp_pkg.sv =====
// Shared types and constants for the neighbor table with random pick.
// Holds the controller/datapath command and status structs; no dependencies.
package ntfrp_pkg;

  localparam int ADDR_W = 16;
  localparam int RND_W  = 16;
  localparam int STEP_W = $clog2(RND_W);

  localparam logic ACTION_ADD  = 1'b0;
  localparam logic ACTION_PICK = 1'b1;

  typedef struct packed {
    logic load;       // capture an input item, clear result
    logic scan_run;   // issue/compare one slot of the search
    logic write;      // store the address at the write cursor
    logic div_run;    // one remainder step
    logic pick_read;  // read the slot selected by the remainder
    logic pick_take;  // latch the picked address into the result
    logic out_load;   // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic is_pick;
    logic addr_zero;
    logic fill_empty;
    logic hit;
    logic scan_end;
    logic div_last;
  } status_t;

endpackage

// ===== src/ntfrp_dpath.sv =====
// Datapath: slot memory, fill count, write cursor, search counter,
// bit-serial remainder unit and output register. Uses ntfrp_pkg.
module ntfrp_dpath #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ntfrp_pkg::cmd_t               cmd,
  output ntfrp_pkg::status_t            status,
  input  logic                          action,
  input  logic [ntfrp_pkg::ADDR_W-1:0]  address,
  input  logic [ntfrp_pkg::RND_W-1:0]   random_value,
  output logic                          found,
  output logic [ntfrp_pkg::ADDR_W-1:0]  neighbor_address,
  output logic                          stored_new
);
  import ntfrp_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [ADDR_W-1:0] slots [TABLE_ENTRIES];
  logic [ADDR_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_addr;

  logic              act_q;
  logic [ADDR_W-1:0] addr_q;
  logic [RND_W-1:0]  rnd_sh;
  logic [CNT_W-1:0]  fill;
  logic [IDX_W-1:0]  cursor;
  logic [IDX_W-1:0]  scan_idx;
  logic              issue_done;
  logic              cmp_v;
  logic              cmp_last;
  logic [CNT_W-1:0]  rem;
  logic [STEP_W-1:0] step;

  logic              res_found;
  logic [ADDR_W-1:0] res_addr;
  logic              res_stored;

  logic [CNT_W-1:0]  fill_m1;
  logic [CNT_W:0]    rem_shift;
  logic [CNT_W:0]    rem_sub;
  logic              rem_ge;

  assign fill_m1   = fill - CNT_W'(1);
  assign rem_shift = {rem, rnd_sh[RND_W-1]};
  assign rem_ge    = rem_shift >= {1'b0, fill};
  assign rem_sub   = rem_shift - {1'b0, fill};
  assign rd_addr   = cmd.pick_read ? rem[IDX_W-1:0] : scan_idx;

  assign status.is_pick    = (act_q == ACTION_PICK);
  assign status.addr_zero  = (addr_q == '0);
  assign status.fill_empty = (fill == '0);
  assign status.hit        = cmp_v && (rd_data == addr_q);
  assign status.scan_end   = cmp_v && cmp_last;
  assign status.div_last   = (step == STEP_W'(RND_W - 1));

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      slots[cursor] <= addr_q;
    end
    rd_data <= slots[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      cursor     <= '0;
      issue_done <= 1'b0;
      cmp_v      <= 1'b0;
    end else begin
      if (cmd.write) begin
        cursor <= (cursor == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : cursor + IDX_W'(1);
        if (fill != CNT_W'(TABLE_ENTRIES)) begin
          fill <= fill + CNT_W'(1);
        end
      end
      if (cmd.load) begin
        issue_done <= 1'b0;
        cmp_v      <= 1'b0;
      end else if (cmd.scan_run) begin
        // the read issued this cycle is compared in the next one
        cmp_v <= !issue_done;
        if (!issue_done) begin
          issue_done <= (CNT_W'(scan_idx) == fill_m1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q      <= action;
      addr_q     <= address;
      rnd_sh     <= random_value;
      scan_idx   <= '0;
      rem        <= '0;
      step       <= '0;
      res_found  <= 1'b0;
      res_addr   <= '0;
      res_stored <= 1'b0;
    end else begin
      if (cmd.scan_run && !issue_done) begin
        cmp_last <= (CNT_W'(scan_idx) == fill_m1);
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmd.div_run) begin
        rem    <= rem_ge ? rem_sub[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        rnd_sh <= rnd_sh << 1;
        step   <= step + STEP_W'(1);
      end
      if (cmd.write) begin
        res_stored <= 1'b1;
      end
      if (cmd.pick_take) begin
        res_found <= 1'b1;
        res_addr  <= rd_data;
      end
    end
    if (cmd.out_load) begin
      found            <= res_found;
      neighbor_address <= res_addr;
      stored_new       <= res_stored;
    end
  end

endmodule

// ===== src/ntfrp_ctrl.sv =====
// Controller state machine: sequences search, write, remainder and pick,
// and owns both handshakes. Uses ntfrp_pkg.
module ntfrp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ntfrp_pkg::status_t  status,
  output ntfrp_pkg::cmd_t     cmd
);
  import ntfrp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_WRITE, S_DIV, S_PICK_RD, S_PICK_DATA, S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    state_next    = state;
    cmd.load      = in_valid && (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (status.is_pick) begin
          state_next = status.fill_empty ? S_DONE : S_DIV;
        end else if (status.addr_zero) begin
          state_next = S_DONE;
        end else begin
          state_next = status.fill_empty ? S_WRITE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (status.hit) begin
          state_next = S_DONE;
        end else if (status.scan_end) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_DONE;
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (status.div_last) state_next = S_PICK_RD;
      end
      S_PICK_RD: begin
        cmd.pick_read = 1'b1;
        state_next    = S_PICK_DATA;
      end
      S_PICK_DATA: begin
        cmd.pick_take = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        cmd.out_load = !out_valid || out_ready;
        if (cmd.out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/neighbor_table_fifo_random_pick_core.sv =====
// Top level of the neighbor address table with FIFO replacement and
// random pick. Joins ntfrp_ctrl and ntfrp_dpath; uses ntfrp_pkg.
//
// Input channel (in_valid/in_ready): action, address, random_value.
//   action 0 adds address unless it is zero or already stored; the write
//   cursor overwrites the oldest entry once the table is full.
//   action 1 picks the stored entry at random_value mod entry count.
// Output channel (out_valid/out_ready): found, neighbor_address,
//   stored_new; exactly one result transfer per input transfer.
// Steps from input transfer to output valid:
//   add of zero or pick from empty table: decode, output load
//   add to empty table: decode, write, output load
//   add with search over n stored entries: decode, one slot read and
//   compare per entry up to a hit or, past the last entry, a write; output load
//   pick: decode, 16 steps of the bit-serial remainder, slot read,
//   capture, output load
// One item at a time; the search over the slot memory (one read per
//   cycle) sets the add rate, so an add takes longer as the table fills.
// Results sit in an output register: a new item is taken while an older
//   result waits, and the block holds in its final state if the receiver
//   still stalls. Reset empties the table (a fill count, no clearing pass)
//   and returns the cursor to slot 0.
module neighbor_table_fifo_random_pick_core #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [ntfrp_pkg::ADDR_W-1:0]  address,
  input  logic [ntfrp_pkg::RND_W-1:0]   random_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [ntfrp_pkg::ADDR_W-1:0]  neighbor_address,
  output logic                          stored_new
);
  import ntfrp_pkg::*;

  cmd_t    cmd;
  status_t status;

  ntfrp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ntfrp_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .action           (action),
    .address          (address),
    .random_value     (random_value),
    .found            (found),
    .neighbor_address (neighbor_address),
    .stored_new       (stored_new)
  );

endmodule
